[sv/afwd_pkg.sv]
// Shared types, widths and constants of the averaged frequency window detector.
package afwd_pkg;

  // Timer ticks in one second
  localparam int unsigned TICKS_PER_SECOND = 1000000;

  // Field and state widths
  localparam int TIME_W  = 32;
  localparam int SPW_W   = 8;
  localparam int THR_W   = 20;
  localparam int SUM_W   = 40;
  localparam int FREQ_W  = 32;
  localparam int FRAC_W  = 8;
  localparam int HALF_W  = SUM_W / 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  // Reset values of the configuration registers
  localparam logic [SPW_W-1:0] SPW_RESET   = SPW_W'(25);
  localparam logic [THR_W-1:0] LOWER_RESET = THR_W'(2970);
  localparam logic [THR_W-1:0] UPPER_RESET = THR_W'(3050);

  // Arithmetic widths derived from the tick rate
  localparam int TICKS_W    = $clog2(TICKS_PER_SECOND + 1);
  localparam int NUM_W      = TICKS_W + SPW_W;
  localparam int DVD_W      = NUM_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int PROD_W     = THR_W + SUM_W;
  localparam int QCMP_W     = (DVD_W > FREQ_W) ? DVD_W : FREQ_W;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES = 2'd0,
    REG_LOWER   = 2'd1,
    REG_UPPER   = 2'd2
  } afwd_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MLO,
    ST_MHI,
    ST_CMP,
    ST_HOLD
  } afwd_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic acc_en;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic cmp_en;
    logic thr_sel;
    logic out_load;
  } afwd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic close;
  } afwd_sts_t;

endpackage

[sv/averaged_frequency_window_detector_unit.sv]
// Top level of the averaged frequency window detector: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | in_edge_time_us
//  out_    | output    | out_valid / out_stall | out_frequency_q8, out_above_upper,
//          |           |                       | out_below_lower, out_out_of_window
//  cfg_    | input     | cfg_wr_en             | cfg_index, cfg_data
//
// An edge that does not close a window leaves the block ready for the next edge.
// An edge that closes a window holds off input while the restoring divider yields
// one quotient bit a cycle, then two threshold products each take two passes of
// the 20x20 multiplier and a compare.
// Synchronous active-low reset restores the register defaults and clears the window.
// A result waiting under out_stall does not block edges until the next window closes.
module averaged_frequency_window_detector_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [afwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afwd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [afwd_pkg::TIME_W-1:0]         in_edge_time_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [afwd_pkg::FREQ_W-1:0]         out_frequency_q8,
  output logic                                out_above_upper,
  output logic                                out_below_lower,
  output logic                                out_out_of_window
);

  afwd_pkg::afwd_cmd_t cmd;
  afwd_pkg::afwd_sts_t sts;

  afwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  afwd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_edge_time_us   (in_edge_time_us),
    .cmd               (cmd),
    .sts               (sts),
    .out_frequency_q8  (out_frequency_q8),
    .out_above_upper   (out_above_upper),
    .out_below_lower   (out_below_lower),
    .out_out_of_window (out_out_of_window)
  );

`ifndef NO_ASSERTIONS
  // An edge inside a window leaves the block ready next cycle
  a_short_edge: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en && !sts.close |=> !in_stall)
    else $error("edge inside a window stalled the input");

  // A closing edge starts the computation and holds off input
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en && sts.close |=> in_stall)
    else $error("closing edge did not start the computation");

  // A loaded word is presented next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded word not presented");

  // Datapath steps never overlap
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.acc_en, cmd.div_step, cmd.mul_lo, cmd.mul_hi, cmd.cmp_en, cmd.out_load}))
    else $error("overlapping datapath commands");
`endif

endmodule

[sv/afwd_ctrl.sv]
// Controller state machine: sequences accumulation, division, threshold checks and output.
module afwd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  afwd_pkg::afwd_sts_t sts,
  output afwd_pkg::afwd_cmd_t cmd
);

  afwd_pkg::afwd_state_t              state_r, state_nxt;
  logic [afwd_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                               pass_r, pass_nxt;
  logic                               out_valid_r, out_valid_nxt;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afwd_pkg::ST_IDLE;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pass_nxt     = pass_r;
    cmd          = '0;
    cmd.thr_sel  = pass_r;
    in_stall     = 1'b1;
    unique case (state_r)
      afwd_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.acc_en = in_valid;
        if (in_valid && sts.close) begin
          state_nxt = afwd_pkg::ST_DIV;
          cnt_nxt   = '0;
        end
      end
      afwd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == afwd_pkg::DIV_CNT_W'(afwd_pkg::DVD_W - 1)) begin
          state_nxt = afwd_pkg::ST_MLO;
          pass_nxt  = 1'b0;
        end
      end
      afwd_pkg::ST_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = afwd_pkg::ST_MHI;
      end
      afwd_pkg::ST_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = afwd_pkg::ST_CMP;
      end
      afwd_pkg::ST_CMP: begin
        cmd.cmp_en = 1'b1;
        if (pass_r) begin
          state_nxt = afwd_pkg::ST_HOLD;
        end else begin
          pass_nxt  = 1'b1;
          state_nxt = afwd_pkg::ST_MLO;
        end
      end
      afwd_pkg::ST_HOLD: begin
        // Wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = afwd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = afwd_pkg::ST_IDLE;
    endcase
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[sv/afwd_dp.sv]
// Datapath: configuration registers, period accumulator, restoring divider and threshold multiplier.
module afwd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [afwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afwd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [afwd_pkg::TIME_W-1:0]         in_edge_time_us,
  input  afwd_pkg::afwd_cmd_t                 cmd,
  output afwd_pkg::afwd_sts_t                 sts,
  output logic [afwd_pkg::FREQ_W-1:0]         out_frequency_q8,
  output logic                                out_above_upper,
  output logic                                out_below_lower,
  output logic                                out_out_of_window
);

  // Configuration
  logic [afwd_pkg::SPW_W-1:0]  spw_r;
  logic [afwd_pkg::THR_W-1:0]  lower_r;
  logic [afwd_pkg::THR_W-1:0]  upper_r;

  // Window accumulation
  logic [afwd_pkg::TIME_W-1:0] prev_r;
  logic [afwd_pkg::SPW_W-1:0]  seen_r;
  logic [afwd_pkg::SUM_W-1:0]  sum_r;

  // Captured window and divider
  logic [afwd_pkg::SUM_W-1:0]  div_sum_r;
  logic [afwd_pkg::NUM_W-1:0]  num_r;
  logic [afwd_pkg::DVD_W-1:0]  quo_r;
  logic [afwd_pkg::SUM_W-1:0]  rem_r;

  // Threshold products and flags
  logic [2*afwd_pkg::HALF_W-1:0] plo_r;
  logic [afwd_pkg::PROD_W-1:0]   prod_r;
  logic                          above_r;
  logic                          below_r;

  // Output word
  logic [afwd_pkg::FREQ_W-1:0] freq_r;
  logic                        out_above_r;
  logic                        out_below_r;
  logic                        out_oow_r;

  logic [afwd_pkg::TIME_W-1:0]   period;
  logic [afwd_pkg::SUM_W-1:0]    sum_inc;
  logic [afwd_pkg::SPW_W-1:0]    seen_inc;
  logic [afwd_pkg::SPW_W-1:0]    target;
  logic [afwd_pkg::NUM_W-1:0]    num_new;
  logic [afwd_pkg::SUM_W:0]      shifted;
  logic [afwd_pkg::SUM_W+1:0]    trial;
  logic [afwd_pkg::THR_W-1:0]    thr;
  logic [2*afwd_pkg::HALF_W-1:0] phi;
  logic [afwd_pkg::PROD_W-1:0]   prod_new;
  logic [afwd_pkg::PROD_W-1:0]   num_ext;
  logic                          sat;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spw_r   <= afwd_pkg::SPW_RESET;
      lower_r <= afwd_pkg::LOWER_RESET;
      upper_r <= afwd_pkg::UPPER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        afwd_pkg::REG_SAMPLES: spw_r   <= cfg_data[afwd_pkg::SPW_W-1:0];
        afwd_pkg::REG_LOWER:   lower_r <= cfg_data[afwd_pkg::THR_W-1:0];
        afwd_pkg::REG_UPPER:   upper_r <= cfg_data[afwd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Period, running sum and window close test
  assign period    = in_edge_time_us - prev_r;
  assign sum_inc   = sum_r + afwd_pkg::SUM_W'(period);
  assign seen_inc  = seen_r + 1'b1;
  assign target    = (spw_r == '0) ? afwd_pkg::SPW_W'(1) : spw_r;
  assign sts.close = (seen_inc >= target);
  assign num_new   = afwd_pkg::NUM_W'(afwd_pkg::TICKS_PER_SECOND)
                     * afwd_pkg::NUM_W'(seen_inc);

  // Accumulate each edge; on window close capture the operands and restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      seen_r <= '0;
      sum_r  <= '0;
    end else if (cmd.acc_en) begin
      prev_r <= in_edge_time_us;
      if (sts.close) begin
        seen_r <= '0;
        sum_r  <= '0;
      end else begin
        seen_r <= seen_inc;
        sum_r  <= sum_inc;
      end
    end
  end

  // Restoring division, one quotient bit a cycle; a zero sum yields all ones
  assign shifted = {rem_r, quo_r[afwd_pkg::DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, div_sum_r};

  always_ff @(posedge clk) begin
    if (cmd.acc_en && sts.close) begin
      div_sum_r <= sum_inc;
      num_r     <= num_new;
      quo_r     <= {num_new, {afwd_pkg::FRAC_W{1'b0}}};
      rem_r     <= '0;
    end else if (cmd.div_step) begin
      if (!trial[afwd_pkg::SUM_W+1]) begin
        rem_r <= trial[afwd_pkg::SUM_W-1:0];
        quo_r <= {quo_r[afwd_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[afwd_pkg::SUM_W-1:0];
        quo_r <= {quo_r[afwd_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  // Threshold times sum in two halves, then the exact compare
  assign thr      = cmd.thr_sel ? lower_r : upper_r;
  assign phi      = afwd_pkg::HALF_W'(thr) * div_sum_r[afwd_pkg::SUM_W-1:afwd_pkg::HALF_W];
  assign prod_new = {phi, {afwd_pkg::HALF_W{1'b0}}} + afwd_pkg::PROD_W'(plo_r);
  assign num_ext  = afwd_pkg::PROD_W'(num_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      plo_r <= afwd_pkg::HALF_W'(thr) * div_sum_r[afwd_pkg::HALF_W-1:0];
    end
    if (cmd.mul_hi) begin
      prod_r <= prod_new;
    end
    if (cmd.cmp_en) begin
      if (cmd.thr_sel) begin
        below_r <= (num_ext < prod_r);
      end else begin
        above_r <= (num_ext > prod_r);
      end
    end
  end

  // Saturate the quotient and load the output word
  assign sat = afwd_pkg::QCMP_W'(quo_r) > afwd_pkg::QCMP_W'({afwd_pkg::FREQ_W{1'b1}});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      freq_r      <= sat ? {afwd_pkg::FREQ_W{1'b1}} : afwd_pkg::FREQ_W'(quo_r);
      out_above_r <= above_r;
      out_below_r <= below_r;
      out_oow_r   <= above_r | below_r;
    end
  end

  assign out_frequency_q8  = freq_r;
  assign out_above_upper   = out_above_r;
  assign out_below_lower   = out_below_r;
  assign out_out_of_window = out_oow_r;

endmodule
